// ===== design/axis_angle_rotation_matrix_unit_macros.svh =====
// Assertion macros shared by the rotation matrix unit
`ifndef AXIS_ANGLE_ROTATION_MATRIX_UNIT_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define AARM_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define AARM_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define AARM_ASSERT_IMP(name, clk, rst_n, pre, post)
`define AARM_ASSERT_NXT(name, clk, rst_n, pre, post)
`endif

`endif

// ===== design/aarm_pkg.sv =====
`timescale 1ns / 1ps

package aarm_pkg;

    localparam int NSTEPS = 16;
    localparam int IDXW   = 4;
    localparam int XW     = 34;
    localparam int ZW     = 25;
    localparam int CW     = 18;
    localparam int QW     = 53;
    localparam int PW     = 32;
    localparam int OW     = CW + 1;
    localparam int MW     = PW + OW;
    localparam int SW     = 16 + CW;
    localparam int RW     = QW - 28;

    localparam logic signed [XW-1:0] CORDIC_INIT  = XW'(652032875);
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(4194304);
    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(8388608);
    localparam logic signed [CW-1:0] TRIG_MAX     = CW'(16448);

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic [15:0]        angle;
    } in_t;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } out_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
        logic signed [15:0]   ax;
        logic signed [15:0]   ay;
        logic signed [15:0]   az;
    } cordic_t;

    function automatic logic signed [ZW-1:0] atan_at(input logic [IDXW-1:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            4'd0:    a = ZW'(2097152);
            4'd1:    a = ZW'(1238021);
            4'd2:    a = ZW'(654136);
            4'd3:    a = ZW'(332050);
            4'd4:    a = ZW'(166669);
            4'd5:    a = ZW'(83416);
            4'd6:    a = ZW'(41718);
            4'd7:    a = ZW'(20860);
            4'd8:    a = ZW'(10430);
            4'd9:    a = ZW'(5215);
            4'd10:   a = ZW'(2608);
            4'd11:   a = ZW'(1304);
            4'd12:   a = ZW'(652);
            4'd13:   a = ZW'(326);
            4'd14:   a = ZW'(163);
            4'd15:   a = ZW'(81);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== design/axis_angle_rotation_matrix_unit.sv =====
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_item  (axis_x, axis_y, axis_z, angle)
// out       out_valid / out_ready  out_item (r00 .. r22)
//
// The pipeline is 16 CORDIC cells, then three matrix stages.
// One item per cycle sustained while out_ready stays high; every stage is a register with its own valid.
// Ready ripples back stage by stage, so empty slots fill while the output waits.
// Reset clears only the valid bits; the data registers are not reset.
module axis_angle_rotation_matrix_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  aarm_pkg::in_t   in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output aarm_pkg::out_t  out_item
);
    import aarm_pkg::*;

    cordic_t              chain [NSTEPS+1];
    logic                 vld   [NSTEPS+1];
    logic                 rdy   [NSTEPS+1];
    logic signed [ZW-1:0] z0;
    logic signed [ZW-1:0] zr;
    logic                 flip;

    always_comb
    begin
        z0   = ZW'($signed({in_item.angle, 8'b0}));
        zr   = z0;
        flip = 1'b0;
        if (z0 > QUARTER_TURN)
        begin
            zr   = z0 - HALF_TURN;
            flip = 1'b1;
        end
        else if (z0 < -QUARTER_TURN)
        begin
            zr   = z0 + HALF_TURN;
            flip = 1'b1;
        end
        chain[0].x    = CORDIC_INIT;
        chain[0].y    = '0;
        chain[0].z    = zr;
        chain[0].flip = flip;
        chain[0].ax   = in_item.axis_x;
        chain[0].ay   = in_item.axis_y;
        chain[0].az   = in_item.axis_z;
    end

    assign vld[0]   = in_valid;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < NSTEPS; k++)
    begin : g_cell
        aarm_cordic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (IDXW'(k)),
            .up_valid (vld[k]),
            .up_ready (rdy[k]),
            .up       (chain[k]),
            .dn_valid (vld[k+1]),
            .dn_ready (rdy[k+1]),
            .dn       (chain[k+1])
        );
    end

    aarm_matrix u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vld[NSTEPS]),
        .up_ready (rdy[NSTEPS]),
        .up       (chain[NSTEPS]),
        .dn_valid (out_valid),
        .dn_ready (out_ready),
        .dn       (out_item)
    );

endmodule

// ===== design/aarm_cordic_cell.sv =====
`timescale 1ns / 1ps

module aarm_cordic_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [aarm_pkg::IDXW-1:0]    idx,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  aarm_pkg::cordic_t            up,
    output logic                         dn_valid,
    input  logic                         dn_ready,
    output aarm_pkg::cordic_t            dn
);
    import aarm_pkg::*;

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] ang;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = data_reg;

    always_comb
    begin
        dx  = up.y >>> idx;
        dy  = up.x >>> idx;
        ang = atan_at(idx);
        data_next = up;
        if (!up.z[ZW-1])
        begin
            data_next.x = up.x - dx;
            data_next.y = up.y + dy;
            data_next.z = up.z - ang;
        end
        else
        begin
            data_next.x = up.x + dx;
            data_next.y = up.y - dy;
            data_next.z = up.z + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== design/aarm_matrix.sv =====
`timescale 1ns / 1ps
`include "axis_angle_rotation_matrix_unit_macros.svh"

module aarm_matrix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  aarm_pkg::cordic_t up,
    output logic              dn_valid,
    input  logic              dn_ready,
    output aarm_pkg::out_t    dn
);
    import aarm_pkg::*;

    function automatic logic signed [15:0] sat16(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] t;
        logic signed [RW-1:0] r;
        logic signed [15:0]   o;
        t = v + (QW'(1) <<< 27);
        r = t[QW-1:28];
        if (r > RW'(32767))
        begin
            o = 16'sh7fff;
        end
        else if (r < -RW'(32768))
        begin
            o = 16'sh8000;
        end
        else
        begin
            o = r[15:0];
        end
        return o;
    endfunction

    // stage A: finish sine/cosine, axis pair products
    logic                 a_valid_reg;
    logic signed [CW-1:0] a_c_reg, a_s_reg;
    logic signed [PW-1:0] a_xx_reg, a_yy_reg, a_zz_reg, a_xy_reg, a_xz_reg, a_yz_reg;
    logic signed [15:0]   a_ax_reg, a_ay_reg, a_az_reg;
    logic signed [XW-1:0] xf, yf, xr, yr;

    // stage B: scale by one minus cosine and by sine
    logic                 b_valid_reg;
    logic signed [CW-1:0] b_c_reg;
    logic signed [MW-1:0] b_xx_reg, b_yy_reg, b_zz_reg, b_xy_reg, b_xz_reg, b_yz_reg;
    logic signed [SW-1:0] b_xs_reg, b_ys_reg, b_zs_reg;
    logic signed [OW-1:0] omc;

    // stage C: sums, round, saturate
    logic                 c_valid_reg;
    out_t                 out_reg;
    out_t                 out_next;
    logic signed [QW-1:0] cq, xs, ys, zs, xx, yy, zz, xy, xz, yz;

    logic a_ready, b_ready, c_ready;

    assign c_ready  = !c_valid_reg || dn_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;
    assign dn_valid = c_valid_reg;
    assign dn       = out_reg;

    always_comb
    begin
        xf = up.flip ? -up.x : up.x;
        yf = up.flip ? -up.y : up.y;
        xr = xf + (XW'(1) <<< 15);
        yr = yf + (XW'(1) <<< 15);
        omc = OW'(16384) - OW'(a_c_reg);
    end

    always_comb
    begin
        cq = QW'(b_c_reg) <<< 28;
        xs = QW'(b_xs_reg) <<< 14;
        ys = QW'(b_ys_reg) <<< 14;
        zs = QW'(b_zs_reg) <<< 14;
        xx = QW'(b_xx_reg);
        yy = QW'(b_yy_reg);
        zz = QW'(b_zz_reg);
        xy = QW'(b_xy_reg);
        xz = QW'(b_xz_reg);
        yz = QW'(b_yz_reg);
        out_next.r00 = sat16(xx + cq);
        out_next.r01 = sat16(xy + zs);
        out_next.r02 = sat16(xz - ys);
        out_next.r10 = sat16(xy - zs);
        out_next.r11 = sat16(yy + cq);
        out_next.r12 = sat16(yz + xs);
        out_next.r20 = sat16(xz + ys);
        out_next.r21 = sat16(yz - xs);
        out_next.r22 = sat16(zz + cq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= up_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && up_valid)
        begin
            a_c_reg  <= xr[XW-1:16];
            a_s_reg  <= yr[XW-1:16];
            a_xx_reg <= PW'(up.ax) * PW'(up.ax);
            a_yy_reg <= PW'(up.ay) * PW'(up.ay);
            a_zz_reg <= PW'(up.az) * PW'(up.az);
            a_xy_reg <= PW'(up.ax) * PW'(up.ay);
            a_xz_reg <= PW'(up.ax) * PW'(up.az);
            a_yz_reg <= PW'(up.ay) * PW'(up.az);
            a_ax_reg <= up.ax;
            a_ay_reg <= up.ay;
            a_az_reg <= up.az;
        end
        if (b_ready && a_valid_reg)
        begin
            b_c_reg  <= a_c_reg;
            b_xx_reg <= MW'(a_xx_reg) * MW'(omc);
            b_yy_reg <= MW'(a_yy_reg) * MW'(omc);
            b_zz_reg <= MW'(a_zz_reg) * MW'(omc);
            b_xy_reg <= MW'(a_xy_reg) * MW'(omc);
            b_xz_reg <= MW'(a_xz_reg) * MW'(omc);
            b_yz_reg <= MW'(a_yz_reg) * MW'(omc);
            b_xs_reg <= SW'(a_ax_reg) * SW'(a_s_reg);
            b_ys_reg <= SW'(a_ay_reg) * SW'(a_s_reg);
            b_zs_reg <= SW'(a_az_reg) * SW'(a_s_reg);
        end
        if (c_ready && b_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    `AARM_ASSERT_NXT(a_stall_hold, clk, rst_n, a_valid_reg && !b_ready, a_valid_reg)
    `AARM_ASSERT_NXT(a_take_item, clk, rst_n, up_valid && up_ready, a_valid_reg)
    `AARM_ASSERT_IMP(cos_range, clk, rst_n, a_valid_reg, (a_c_reg <= TRIG_MAX) && (a_c_reg >= -TRIG_MAX))
    `AARM_ASSERT_IMP(sin_range, clk, rst_n, a_valid_reg, (a_s_reg <= TRIG_MAX) && (a_s_reg >= -TRIG_MAX))

endmodule
